// ===== rtl/core/modbus_rtu_slave_frame_checker_core_defines.svh =====
// Assertion macros shared by the frame checker RTL.
// Expects clk and rst to be visible in the including module.
`ifndef MODBUS_RTU_SLAVE_FRAME_CHECKER_CORE_DEFINES_SVH
`define MODBUS_RTU_SLAVE_FRAME_CHECKER_CORE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define MRFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset.
`define MRFC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/mrfc_pkg.sv =====
// Package for the Modbus RTU frame checker: status codes, frame constants,
// the front-to-back command type and the CRC-16/MODBUS byte step.
`timescale 1ns / 1ps

package mrfc_pkg;

  localparam logic [2:0] ST_TEMP       = 3'd0;
  localparam logic [2:0] ST_HUM        = 3'd1;
  localparam logic [2:0] ST_OTHER      = 3'd2;
  localparam logic [2:0] ST_CRC_BAD    = 3'd3;
  localparam logic [2:0] ST_WRONG_ADDR = 3'd4;
  localparam logic [2:0] ST_REPLY      = 3'd5;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [7:0]  BYTE_COUNT      = 8'h02;
  localparam logic [7:0]  REQ_TEMPERATURE = 8'h01;
  localparam logic [7:0]  REQ_HUMIDITY    = 8'h02;
  localparam logic [7:0]  ADDR_RESET      = 8'h06;

  // Frame byte positions
  localparam logic [2:0] POS_HUNT     = 3'd0;
  localparam logic [2:0] POS_REG      = 3'd3;
  localparam logic [2:0] POS_LAST_CRC = 3'd5;
  localparam logic [2:0] POS_CRC_LO   = 3'd6;
  localparam logic [2:0] POS_CRC_HI   = 3'd7;

  // Reply byte indexes
  localparam logic [2:0] RB_ADDR   = 3'd0;
  localparam logic [2:0] RB_FUNC   = 3'd1;
  localparam logic [2:0] RB_COUNT  = 3'd2;
  localparam logic [2:0] RB_VAL_HI = 3'd3;
  localparam logic [2:0] RB_VAL_LO = 3'd4;
  localparam logic [2:0] RB_CRC_LO = 3'd5;
  localparam logic [2:0] RB_CRC_HI = 3'd6;

  typedef struct packed {
    logic        is_reply;
    logic [2:0]  status;
    logic [7:0]  address;
    logic [15:0] value;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mrfc_if.sv =====
// Valid/ready channel interfaces for the frame checker request and response.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface mrfc_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  rx_byte;
  logic [15:0] sensor_value;

  modport source (output valid, output op, output rx_byte, output sensor_value,
                  input ready);
  modport sink (input valid, input op, input rx_byte, input sensor_value,
                output ready);
endinterface

interface mrfc_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, output status, output tx_byte, output last,
                  input ready);
  modport sink (input valid, input status, input tx_byte, input last,
                output ready);
endinterface

// ===== rtl/core/modbus_rtu_slave_frame_checker_core.sv =====
// Modbus RTU slave frame checker. Request items are taken one per clock
// cycle whenever the command queue (QUEUE_DEPTH entries) has room. A frame
// byte that completes a frame, or a hunted byte with the wrong address, gives
// one status item; a reply request with a valid frame pending gives seven
// reply-byte items as the back end steps its CRC over the message. The
// response side runs at one item per cycle while rsp.ready is high, and a
// reply holds the queue head through its last byte; the request side
// stalls only when the queue fills behind it. Write the slave address on
// cfg_wr_en/cfg_wr_data only while the block is idle; it resets to 6.
`timescale 1ns / 1ps

module modbus_rtu_slave_frame_checker_core
  import mrfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  mrfc_req_if.sink   req,
  mrfc_rsp_if.source rsp
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  mrfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  mrfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  mrfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule

// ===== rtl/core/mrfc_front.sv =====
// Front end: takes request items, tracks the frame and its CRC, holds the
// slave address and pushes commands into the queue. Uses mrfc_pkg, mrfc_if.
`timescale 1ns / 1ps

module mrfc_front
  import mrfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  mrfc_req_if.sink    req,
  input  logic        q_full,
  output logic        push,
  output cmd_t        push_cmd
);

  logic [7:0]  own_addr;
  logic [2:0]  byte_position;
  logic [15:0] crc_register;
  logic [7:0]  register_byte;
  logic [7:0]  received_crc_low;
  logic        reply_pending;

  logic        accept;
  logic        addr_match;
  logic        crc_ok;
  logic [2:0]  kind;

  assign req.ready  = !q_full;
  assign accept     = req.valid && req.ready;
  assign addr_match = (req.rx_byte == own_addr);
  assign crc_ok     = (received_crc_low == crc_register[7:0]) &&
                      (req.rx_byte == crc_register[15:8]);

  always_comb begin
    if (register_byte == REQ_TEMPERATURE) begin
      kind = ST_TEMP;
    end else if (register_byte == REQ_HUMIDITY) begin
      kind = ST_HUM;
    end else begin
      kind = ST_OTHER;
    end
  end

  always_comb begin
    push              = 1'b0;
    push_cmd.is_reply = 1'b0;
    push_cmd.status   = ST_WRONG_ADDR;
    push_cmd.address  = own_addr;
    push_cmd.value    = req.sensor_value;
    if (accept) begin
      if (req.op) begin
        push              = reply_pending;
        push_cmd.is_reply = 1'b1;
        push_cmd.status   = ST_REPLY;
      end else if (byte_position == POS_HUNT) begin
        push = !addr_match;
      end else if (byte_position == POS_CRC_HI) begin
        push            = 1'b1;
        push_cmd.status = crc_ok ? kind : ST_CRC_BAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr         <= ADDR_RESET;
      byte_position    <= POS_HUNT;
      crc_register     <= CRC_INIT;
      register_byte    <= 8'h00;
      received_crc_low <= 8'h00;
      reply_pending    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        own_addr <= cfg_wr_data;
      end
      if (accept) begin
        if (req.op) begin
          reply_pending <= 1'b0;
        end else begin
          case (byte_position)
            POS_HUNT: begin
              if (addr_match) begin
                crc_register  <= crc_byte(CRC_INIT, req.rx_byte);
                byte_position <= byte_position + 3'd1;
              end
            end
            POS_CRC_LO: begin
              received_crc_low <= req.rx_byte;
              byte_position    <= POS_CRC_HI;
            end
            POS_CRC_HI: begin
              byte_position <= POS_HUNT;
              reply_pending <= crc_ok;
              crc_register  <= CRC_INIT;
            end
            default: begin
              // frame bytes one to five feed the CRC
              if (byte_position == POS_REG) begin
                register_byte <= req.rx_byte;
              end
              crc_register  <= crc_byte(crc_register, req.rx_byte);
              byte_position <= byte_position + 3'd1;
            end
          endcase
        end
      end
    end
  end

endmodule

// ===== rtl/core/mrfc_queue.sv =====
// Command queue between front and back: a small register FIFO.
// Uses mrfc_pkg for the command type and the shared assertion macros.
`timescale 1ns / 1ps
`include "modbus_rtu_slave_frame_checker_core_defines.svh"

module mrfc_queue
  import mrfc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `MRFC_NEVER(a_no_push_full, push && full, "push into full queue")
  `MRFC_NEVER(a_no_pop_empty, pop && !head_valid, "pop from empty queue")
  `MRFC_ASSERT(a_count_up, push && !pop |=> count == $past(count) + CW'(1), "count not advanced")

endmodule

// ===== rtl/core/mrfc_back.sv =====
// Back end: turns queued commands into response items, one status item or a
// seven-byte reply with its CRC built byte by byte. Uses mrfc_pkg, mrfc_if.
`timescale 1ns / 1ps
`include "modbus_rtu_slave_frame_checker_core_defines.svh"

module mrfc_back
  import mrfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  cmd_t      head_cmd,
  output logic      pop,
  mrfc_rsp_if.source rsp
);

  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [2:0]  idx;
  logic [15:0] crc;

  logic        load;
  logic [7:0]  reply_byte;
  logic [15:0] crc_base;

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.tx_byte = out_byte;
  assign rsp.last    = out_last;

  assign load     = head_valid && (!out_valid || rsp.ready);
  assign pop      = load && (!head_cmd.is_reply || idx == RB_CRC_HI);
  assign crc_base = (idx == RB_ADDR) ? CRC_INIT : crc;

  always_comb begin
    case (idx)
      RB_ADDR:   reply_byte = head_cmd.address;
      RB_FUNC:   reply_byte = FUNC_READ_INPUT;
      RB_COUNT:  reply_byte = BYTE_COUNT;
      RB_VAL_HI: reply_byte = head_cmd.value[15:8];
      RB_VAL_LO: reply_byte = head_cmd.value[7:0];
      RB_CRC_LO: reply_byte = crc[7:0];
      RB_CRC_HI: reply_byte = crc[15:8];
      default:   reply_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= RB_ADDR;
    end else if (load) begin
      out_valid <= 1'b1;
      if (head_cmd.is_reply) begin
        out_status <= ST_REPLY;
        out_byte   <= reply_byte;
        out_last   <= (idx == RB_CRC_HI);
        // fold the message bytes, hold the CRC for the two trailing bytes
        if (idx < RB_CRC_LO) begin
          crc <= crc_byte(crc_base, reply_byte);
        end
        idx <= (idx == RB_CRC_HI) ? RB_ADDR : idx + 3'd1;
      end else begin
        out_status <= head_cmd.status;
        out_byte   <= 8'h00;
        out_last   <= 1'b1;
      end
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  `MRFC_ASSERT(a_idx_reply, idx != RB_ADDR |-> head_valid && head_cmd.is_reply, "reply lost mid-send")
  `MRFC_ASSERT(a_status_last, out_valid && out_status != ST_REPLY |-> out_last, "status without last")
  `MRFC_ASSERT(a_last_idx, out_valid && out_status == ST_REPLY && out_last |-> idx == RB_ADDR, "reply index not rewound")

endmodule

// ===== tb/sv/mrfc_tb_pkg.sv =====
// Shared testbench helpers for the Modbus RTU frame checker: request op codes
// and a bitwise CRC-16/MODBUS byte step. Depends on mrfc_pkg for the CRC polynomial.
`timescale 1ns / 1ps

package mrfc_tb_pkg;

  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_REPLY   = 1'b1;

  // Shift one byte through the reflected CRC, LSB first
  function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                    input logic [7:0]  data);
    logic [15:0] r;
    r = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = {1'b0, r[15:1]} ^ mrfc_pkg::CRC_POLY;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

endpackage

// ===== tb/sv/mrfc_frame_monitor.sv =====
// Watches the request, response and address-write ports of the frame checker,
// predicts every status and reply byte, and compares in order.
// Depends on mrfc_pkg, mrfc_tb_pkg and the mrfc_req_if / mrfc_rsp_if interfaces.
`timescale 1ns / 1ps

module mrfc_frame_monitor
  import mrfc_pkg::*;
  import mrfc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  mrfc_req_if         req,
  mrfc_rsp_if         rsp,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] tx_byte;
    logic       last;
  } rsp_item_t;

  rsp_item_t   due_rsp [$];
  logic [7:0]  slave_addr;
  logic [2:0]  frame_pos;
  logic [15:0] frame_crc;
  logic [7:0]  reg_sel;
  logic [7:0]  crc_lo_rx;
  logic        reply_armed;
  int unsigned fail_count = 0;

  task automatic absorb_request(input logic op, input logic [7:0] b,
                                input logic [15:0] v);
    logic [7:0]  msg [7];
    logic [15:0] c;
    logic [2:0]  kind;
    if (op == OP_REPLY) begin
      if (reply_armed) begin
        reply_armed    = 1'b0;
        msg[RB_ADDR]   = slave_addr;
        msg[RB_FUNC]   = FUNC_READ_INPUT;
        msg[RB_COUNT]  = BYTE_COUNT;
        msg[RB_VAL_HI] = v[15:8];
        msg[RB_VAL_LO] = v[7:0];
        c = CRC_INIT;
        for (int i = 0; i < 5; i++) c = crc16_modbus_step(c, msg[3'(i)]);
        msg[RB_CRC_LO] = c[7:0];
        msg[RB_CRC_HI] = c[15:8];
        for (int i = 0; i < 7; i++) begin
          due_rsp.push_back(rsp_item_t'{ST_REPLY, msg[3'(i)], i == RB_CRC_HI});
        end
      end
    end else if (frame_pos == POS_HUNT) begin
      if (b != slave_addr) begin
        due_rsp.push_back(rsp_item_t'{ST_WRONG_ADDR, 8'h00, 1'b1});
      end else begin
        frame_crc = crc16_modbus_step(CRC_INIT, b);
        frame_pos = 3'd1;
      end
    end else if (frame_pos <= POS_LAST_CRC) begin
      if (frame_pos == POS_REG) reg_sel = b;
      frame_crc = crc16_modbus_step(frame_crc, b);
      frame_pos = frame_pos + 3'd1;
    end else if (frame_pos == POS_CRC_LO) begin
      crc_lo_rx = b;
      frame_pos = POS_CRC_HI;
    end else begin
      frame_pos = POS_HUNT;
      if (crc_lo_rx == frame_crc[7:0] && b == frame_crc[15:8]) begin
        kind = (reg_sel == REQ_TEMPERATURE) ? ST_TEMP :
               (reg_sel == REQ_HUMIDITY)    ? ST_HUM  : ST_OTHER;
        reply_armed = 1'b1;
        due_rsp.push_back(rsp_item_t'{kind, 8'h00, 1'b1});
      end else begin
        // a bad frame drops any reply still owed
        reply_armed = 1'b0;
        due_rsp.push_back(rsp_item_t'{ST_CRC_BAD, 8'h00, 1'b1});
      end
      frame_crc = CRC_INIT;
    end
  endtask

  always @(posedge clk) begin
    rsp_item_t seen;
    rsp_item_t want;
    if (rst) begin
      slave_addr  = ADDR_RESET;
      frame_pos   = POS_HUNT;
      frame_crc   = CRC_INIT;
      reg_sel     = 8'h00;
      crc_lo_rx   = 8'h00;
      reply_armed = 1'b0;
      due_rsp.delete();
    end else begin
      if (cfg_wr_en) slave_addr = cfg_wr_data;
      // requests first, so a same-edge result is already predicted
      if (req.valid && req.ready) absorb_request(req.op, req.rx_byte, req.sensor_value);
      if (rsp.valid && rsp.ready) begin
        seen = rsp_item_t'{rsp.status, rsp.tx_byte, rsp.last};
        if (due_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected item status=%0d tx_byte=%02h last=%0b",
                     $realtime, seen.status, seen.tx_byte, seen.last);
          end
        end else begin
          want = due_rsp.pop_front();
          if (seen.status !== want.status || seen.tx_byte !== want.tx_byte ||
              seen.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: item mismatch exp status=%0d tx_byte=%02h last=%0b",
                       $realtime, want.status, want.tx_byte, want.last);
              $display("%0t:               got status=%0d tx_byte=%02h last=%0b",
                       $realtime, seen.status, seen.tx_byte, seen.last);
            end
          end
        end
      end
    end
    mismatches  <= fail_count;
    outstanding <= due_rsp.size();
  end

endmodule

// ===== tb/sv/modbus_rtu_slave_frame_checker_core_tb.sv =====
// Top of the frame checker testbench: clock, reset, address writes, request
// and response stimulus with random gaps, and the verdict.
// Depends on mrfc_pkg, mrfc_tb_pkg, the channel interfaces and mrfc_frame_monitor.
`timescale 1ns / 1ps

module modbus_rtu_slave_frame_checker_core_tb;
  import mrfc_pkg::*;
  import mrfc_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int NO_REPLY        = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          quiet_tx = 1'b0;
  bit          quiet_rx = 1'b0;
  bit          hold_rsp = 1'b0;
  logic [7:0]  cur_addr = ADDR_RESET;
  logic [7:0]  frame_bytes [8];

  mrfc_req_if req ();
  mrfc_rsp_if rsp ();

  modbus_rtu_slave_frame_checker_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp)
  );

  mrfc_frame_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic put_item(input logic op, input logic [7:0] b, input logic [15:0] v);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.op           <= op;
    req.rx_byte      <= b;
    req.sensor_value <= v;
    do @(posedge clk); while (!req.ready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    put_item(OP_RX_BYTE, b, 16'($urandom));
  endtask

  task automatic send_reply(input logic [15:0] v);
    put_item(OP_REPLY, 8'($urandom), v);
  endtask

  function automatic void make_frame(input logic [7:0] a, input logic [7:0] fn,
                                     input logic [7:0] r);
    logic [15:0] c;
    frame_bytes[0] = a;
    frame_bytes[1] = fn;
    frame_bytes[2] = 8'($urandom);
    frame_bytes[3] = r;
    frame_bytes[4] = 8'($urandom);
    frame_bytes[5] = 8'($urandom);
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) c = crc16_modbus_step(c, frame_bytes[3'(i)]);
    frame_bytes[POS_CRC_LO] = c[7:0];
    frame_bytes[POS_CRC_HI] = c[15:8];
  endfunction

  // Send frame bytes [from, to), slipping a reply item in before byte 'at'
  task automatic send_frame(input int from, input int to, input int at,
                            input logic [15:0] rv);
    for (int i = from; i < to; i++) begin
      if (i == at) send_reply(rv);
      send_byte(frame_bytes[3'(i)]);
    end
  endtask

  // Drop valid, wait for every predicted item, then let the pipeline empty
  task automatic settle();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_address(input logic [7:0] a);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_addr = a;
  endtask

  task automatic random_episode();
    int pick;
    int idx;
    int at;
    logic [7:0] fn;
    logic [7:0] r;
    if ($urandom_range(0, 7) == 0) quiet_tx = !quiet_tx;
    pick = $urandom_range(0, 99);
    fn = ($urandom_range(0, 3) == 0) ? 8'($urandom) : FUNC_READ_INPUT;
    case ($urandom_range(0, 2))
      0:       r = REQ_TEMPERATURE;
      1:       r = REQ_HUMIDITY;
      default: r = 8'($urandom);
    endcase
    if (pick < 60) begin
      make_frame(cur_addr, fn, r);
      if ($urandom_range(0, 99) < 15) begin
        idx = $urandom_range(1, 7);
        frame_bytes[3'(idx)] = frame_bytes[3'(idx)] ^ 8'(1 << $urandom_range(0, 7));
      end
      at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : NO_REPLY;
      send_frame(0, 8, at, 16'($urandom));
    end else if (pick < 80) begin
      send_reply(16'($urandom));
    end else if (pick < 90) begin
      // truncated frame: the following bytes complete it
      make_frame(cur_addr, fn, r);
      send_frame(0, $urandom_range(1, 7), NO_REPLY, 16'h0000);
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  // Response side: random ready gaps, plus one long hold-off on request
  initial begin
    int gap;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) quiet_rx = !quiet_rx;
      gap = quiet_rx ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  initial begin
    int unsigned phase_end;
    logic [7:0]  next_addr;
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= 8'h00;
    req.valid        <= 1'b0;
    req.op           <= OP_RX_BYTE;
    req.rx_byte      <= 8'h00;
    req.sensor_value <= 16'h0000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_address(8'hFF);
    send_byte(8'h00);
    make_frame(cur_addr, FUNC_READ_INPUT, REQ_TEMPERATURE);
    send_frame(0, 8, NO_REPLY, 16'h0000);
    // reply owed by the temperature frame goes out mid-frame
    make_frame(cur_addr, 8'hFF, REQ_HUMIDITY);
    send_frame(0, 8, int'(POS_REG), 16'hFFFF);
    make_frame(cur_addr, FUNC_READ_INPUT, 8'h00);
    frame_bytes[POS_CRC_HI] = frame_bytes[POS_CRC_HI] ^ 8'h80;
    send_frame(0, 8, NO_REPLY, 16'h0000);
    send_reply(16'h0000);

    // change the address halfway through a frame; reply carries the new one
    settle();
    set_address(8'h00);
    make_frame(cur_addr, FUNC_READ_INPUT, 8'hFF);
    send_frame(0, 5, NO_REPLY, 16'h0000);
    settle();
    set_address(ADDR_RESET);
    send_frame(5, 8, NO_REPLY, 16'h0000);
    send_reply(16'h0000);

    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        1:       next_addr = 8'hFF;
        2:       next_addr = 8'h00;
        default: next_addr = 8'($urandom);
      endcase
      set_address(next_addr);
      if (p == 0) begin
        // back-to-back wrong addresses against a stalled receiver
        hold_rsp = 1'b1;
        quiet_tx = 1'b1;
        repeat (40) send_byte(cur_addr ^ 8'($urandom_range(1, 255)));
        quiet_tx = 1'b0;
      end
      phase_end = items_sent + 60;
      while (items_sent < phase_end) random_episode();
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
